/* hw/rtl/afc_pkg.sv */
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and constants for the box frustum culling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package afc_pkg;

  localparam int PLANE_COUNT_DEF = 6;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VAL_W           = 32;
  localparam int PROD_W          = 2 * VAL_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int ROWS            = 3;
  localparam int CORNERS         = 8;

  localparam logic [1:0] KIND_PLANE = 2'd0;
  localparam logic [1:0] KIND_ROW   = 2'd1;
  localparam logic [1:0] KIND_TEST  = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [2:0]          slot;
    logic [5:0][VAL_W-1:0] val;
  } item_t;

  typedef logic [CORNERS-1:0][ROWS-1:0][VAL_W-1:0] pts_t;

  function automatic val_t sat_val(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(2147483647);
    lo = -SUM_W'(64'sd2147483648);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/afc_xform.sv */
// ----------------------------------------------------------------------------
// afc_xform
// Holds the affine transform and turns a box into eight transformed corners
// over three register stages.
// ----------------------------------------------------------------------------
`default_nettype none
module afc_xform import afc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_vld,
  input  wire item_t in_item,
  output logic       out_vld,
  output item_t      out_item,
  output pts_t       out_pts
);

  logic [ROWS-1:0][3:0][VAL_W-1:0] mtx;
  logic  valid1;
  item_t item1;
  logic  valid2;
  item_t item2;
  logic signed [PROD_W-1:0] prod_lo [ROWS][ROWS];
  logic signed [PROD_W-1:0] prod_hi [ROWS][ROWS];
  logic [ROWS-1:0][VAL_W-1:0] trans2;
  pts_t pts_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) begin
        for (int j = 0; j < 4; j++) begin
          mtx[i][j] <= (i == j) ? VAL_W'(1) << FRAC_BITS : '0;
        end
      end
    end else if (adv && valid1 && item1.kind == KIND_ROW && item1.slot < 3'd3) begin
      for (int j = 0; j < 4; j++) begin
        mtx[item1.slot[1:0]][j] <= item1.val[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1  <= 1'b0;
      valid2  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      valid1  <= in_vld;
      valid2  <= valid1;
      out_vld <= valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item1 <= in_item;
      item2 <= item1;
      for (int i = 0; i < ROWS; i++) begin
        for (int j = 0; j < ROWS; j++) begin
          prod_lo[i][j] <= $signed(mtx[i][j]) * $signed(item1.val[j]);
          prod_hi[i][j] <= $signed(mtx[i][j]) * $signed(item1.val[j+3]);
        end
        trans2[i] <= mtx[i][3];
      end
      out_item <= item2;
      out_pts  <= pts_next;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [PROD_W-1:0] p;
    for (int c = 0; c < CORNERS; c++) begin
      for (int i = 0; i < ROWS; i++) begin
        acc = SUM_W'($signed(trans2[i]));
        for (int j = 0; j < ROWS; j++) begin
          p = ((c >> j) & 1) != 0 ? prod_hi[i][j] : prod_lo[i][j];
          acc = acc + SUM_W'(p >>> FRAC_BITS);
        end
        pts_next[c][i] = sat_val(acc);
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/afc_plane.sv */
// ----------------------------------------------------------------------------
// afc_plane
// Holds the frustum planes, takes every corner's distance to every plane
// and registers the visible and straddle flags.
// ----------------------------------------------------------------------------
`default_nettype none
module afc_plane import afc_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  adv,
  input  wire logic  in_vld,
  input  wire item_t in_item,
  input  wire pts_t  in_pts,
  output logic       out_vld,
  output logic       out_visible,
  output logic       out_straddles
);

  localparam int PI_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;

  logic [PLANE_COUNT-1:0][3:0][VAL_W-1:0] pln;
  logic valid4;
  logic signed [PROD_W-1:0] prod4 [PLANE_COUNT][CORNERS][ROWS];
  logic [PLANE_COUNT-1:0][VAL_W-1:0] off4;
  logic visible_next;
  logic straddles_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pln <= '0;
    end else if (adv && in_vld && in_item.kind == KIND_PLANE &&
                 32'(in_item.slot) < PLANE_COUNT) begin
      for (int j = 0; j < 4; j++) begin
        pln[PI_W'(in_item.slot)][j] <= in_item.val[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4  <= 1'b0;
      out_vld <= 1'b0;
    end else if (adv) begin
      valid4  <= in_vld && in_item.kind == KIND_TEST;
      out_vld <= valid4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int c = 0; c < CORNERS; c++) begin
          for (int i = 0; i < ROWS; i++) begin
            prod4[p][c][i] <= $signed(pln[p][i]) * $signed(in_pts[c][i]);
          end
        end
        off4[p] <= pln[p][3];
      end
      out_visible   <= visible_next;
      out_straddles <= straddles_next;
    end
  end

  // The sign of a saturated distance equals the sign of the exact sum.
  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic [CORNERS-1:0] behind;
    visible_next   = 1'b1;
    straddles_next = 1'b0;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int c = 0; c < CORNERS; c++) begin
        acc = -SUM_W'($signed(off4[p]));
        for (int i = 0; i < ROWS; i++) begin
          acc = acc + SUM_W'(prod4[p][c][i] >>> FRAC_BITS);
        end
        behind[c] = acc[SUM_W-1];
      end
      if (&behind) begin
        visible_next = 1'b0;
      end else if (|behind) begin
        straddles_next = 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/aabb_frustum_cull.sv */
// A test item's result is offered after the transform and plane stages.
// Throughput: one item per cycle unless stalled; loads take a slot, no result.
// The pipeline has four stages and one output register; all advance together.
// A plane or transform load takes effect for every later test item.
// Reset is synchronous: identity transform, zero planes, pipeline empty.
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Six-plane frustum culling of transformed axis-aligned boxes in Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none
module aabb_frustum_cull import afc_pkg::*; #(
  parameter int PLANE_COUNT = PLANE_COUNT_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       kind,
  input  wire logic [2:0]       slot,
  input  wire logic [VAL_W-1:0] val0,
  input  wire logic [VAL_W-1:0] val1,
  input  wire logic [VAL_W-1:0] val2,
  input  wire logic [VAL_W-1:0] val3,
  input  wire logic [VAL_W-1:0] val4,
  input  wire logic [VAL_W-1:0] val5,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  visible,
  output logic                  straddles
);

  logic  adv;
  item_t in_item;
  logic  x_vld;
  item_t x_item;
  pts_t  x_pts;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_comb begin
    in_item.kind   = kind;
    in_item.slot   = slot;
    in_item.val[0] = val0;
    in_item.val[1] = val1;
    in_item.val[2] = val2;
    in_item.val[3] = val3;
    in_item.val[4] = val4;
    in_item.val[5] = val5;
  end

  afc_xform #(.FRAC_BITS(FRAC_BITS)) u_xform (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_item  (in_item),
    .out_vld  (x_vld),
    .out_item (x_item),
    .out_pts  (x_pts)
  );

  afc_plane #(.PLANE_COUNT(PLANE_COUNT), .FRAC_BITS(FRAC_BITS)) u_plane (
    .clk           (clk),
    .rst           (rst),
    .adv           (adv),
    .in_vld        (x_vld),
    .in_item       (x_item),
    .in_pts        (x_pts),
    .out_vld       (out_valid),
    .out_visible   (visible),
    .out_straddles (straddles)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(visible) && $stable(straddles))
    else $error("stalled result changed");
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");
  a_out_known: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !$isunknown({visible, straddles}))
    else $error("offered result has unknown bits");

endmodule
`default_nettype wire

/* tb/tb_aabb_frustum_cull.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aabb_frustum_cull
// Loads planes and transform rows, streams boxes through the culler and
// checks each visible/straddle pair against a bit-accurate Q16.16 predictor,
// under several patterns of sender idling and receiver back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_aabb_frustum_cull import afc_pkg::*; ();

  localparam int NPL = PLANE_COUNT_DEF;
  localparam int FB  = FRAC_BITS_DEF;
  localparam logic [1:0] KIND_BAD = 2'd3;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  slot;
    logic [31:0] v [6];
  } cull_item_t;

  typedef struct {
    logic vis;
    logic strad;
  } cull_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [2:0] slot = '0;
  logic [31:0] val0 = '0, val1 = '0, val2 = '0, val3 = '0, val4 = '0, val5 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic visible, straddles;

  aabb_frustum_cull dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .slot(slot), .val0(val0), .val1(val1), .val2(val2),
    .val3(val3), .val4(val4), .val5(val5), .out_valid(out_valid),
    .out_ready(out_ready), .visible(visible), .straddles(straddles)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cull_item_t pending_items[$];
  cull_res_t  expected_culls[$];
  longint     planes [NPL][4];
  longint     xform [3][4];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         hold_send = 1'b0;

  function automatic longint fshift(longint x);
    return x >>> FB;
  endfunction

  function automatic longint sat(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sx(logic [31:0] x);
    return longint'($signed(x));
  endfunction

  task automatic predict_cull(cull_item_t it);
    longint v [6];
    longint corner [3];
    longint pts [8][3];
    longint d;
    int behind, front;
    cull_res_t r;
    for (int i = 0; i < 6; i++) v[i] = sx(it.v[i]);
    if (it.kind == KIND_PLANE) begin
      if (it.slot < NPL) for (int i = 0; i < 4; i++) planes[it.slot][i] = v[i];
    end else if (it.kind == KIND_ROW) begin
      if (it.slot < 3) for (int i = 0; i < 4; i++) xform[it.slot][i] = v[i];
    end else if (it.kind == KIND_TEST) begin
      r.vis = 1'b1;
      r.strad = 1'b0;
      for (int c = 0; c < 8; c++) begin
        corner[0] = c[0] ? v[3] : v[0];
        corner[1] = c[1] ? v[4] : v[1];
        corner[2] = c[2] ? v[5] : v[2];
        for (int i = 0; i < 3; i++)
          pts[c][i] = sat(fshift(xform[i][0] * corner[0]) + fshift(xform[i][1] * corner[1])
                          + fshift(xform[i][2] * corner[2]) + xform[i][3]);
      end
      for (int p = 0; p < NPL; p++) begin
        behind = 0;
        front = 0;
        for (int c = 0; c < 8; c++) begin
          d = sat(fshift(planes[p][0] * pts[c][0]) + fshift(planes[p][1] * pts[c][1])
                  + fshift(planes[p][2] * pts[c][2]) - planes[p][3]);
          if (d < 0) behind++;
          else front++;
        end
        if (front == 0) r.vis = 1'b0;
        else if (behind != 0) r.strad = 1'b1;
      end
      expected_culls.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic [31:0] rnd_val(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
      default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
  endfunction

  function automatic cull_item_t mk(logic [1:0] k, int s, logic [31:0] a,
                                   logic [31:0] b, logic [31:0] c, logic [31:0] d,
                                   logic [31:0] e, logic [31:0] f);
    cull_item_t it;
    it.kind = k;
    it.slot = 3'(s);
    it.v[0] = a; it.v[1] = b; it.v[2] = c; it.v[3] = d; it.v[4] = e; it.v[5] = f;
    return it;
  endfunction

  function automatic cull_item_t rnd_item();
    cull_item_t it;
    int sel, mode;
    sel = $urandom_range(0, 99);
    mode = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
    for (int i = 0; i < 6; i++) it.v[i] = rnd_val(mode);
    it.slot = 3'($urandom);
    if (sel < 12) begin
      it.kind = KIND_PLANE;
      if (sel < 10) it.slot = 3'($urandom_range(0, 5));
    end else if (sel < 17) begin
      it.kind = KIND_ROW;
      if (sel < 15) begin
        it.slot = 3'($urandom_range(0, 2));
        // Keep most transforms near identity so boxes still meet the planes.
        for (int i = 0; i < 3; i++)
          if ($urandom_range(0, 3) != 0)
            it.v[i] = (i == int'(it.slot)) ?
                      32'h0001_0000 + 32'($signed(rnd_val(1)) / 4) :
                      32'($signed(rnd_val(1)) / 8);
      end
    end else if (sel < 19) begin
      it.kind = KIND_BAD;
    end else begin
      it.kind = KIND_TEST;
    end
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_culls.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_cull(pending_items.pop_front());
      if (pending_items.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        kind <= pending_items[0].kind;
        slot <= pending_items[0].slot;
        val0 <= pending_items[0].v[0];
        val1 <= pending_items[0].v[1];
        val2 <= pending_items[0].v[2];
        val3 <= pending_items[0].v[3];
        val4 <= pending_items[0].v[4];
        val5 <= pending_items[0].v[5];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_culls.size() == 0) begin
          report_mismatch("result with no expectation");
        end else begin
          if (visible !== expected_culls[0].vis)
            report_mismatch($sformatf("visible %b exp %b", visible, expected_culls[0].vis));
          if (straddles !== expected_culls[0].strad)
            report_mismatch($sformatf("straddles %b exp %b", straddles,
                                      expected_culls[0].strad));
          void'(expected_culls.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int idle_s [4] = '{0, 67, 0, 26};
    int idle_r [4] = '{0, 0, 67, 26};
    for (int p = 0; p < NPL; p++) for (int i = 0; i < 4; i++) planes[p][i] = 0;
    for (int r = 0; r < 3; r++) for (int i = 0; i < 4; i++)
      xform[r][i] = (r == i) ? 64'sd65536 : 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero planes, extremes, ignored slots, unknown kind, min above max.
    pending_items.push_back(mk(KIND_TEST, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_items.push_back(mk(KIND_PLANE, 0, 32'h0001_0000, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 1, 32'hffff_0000, 0, 0, 32'hfff6_0000, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 2, 0, 32'h0001_0000, 0, 32'hfff6_0000, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 3, 0, 32'hffff_0000, 0, 32'hfff6_0000, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 4, 0, 0, 32'h0001_0000, 32'hfff6_0000, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 5, 0, 0, 32'hffff_0000, 32'hfff6_0000, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                               32'h7fff_ffff, 0, 0));
    pending_items.push_back(mk(KIND_PLANE, 7, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0));
    pending_items.push_back(mk(KIND_TEST, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                               32'h0002_0000, 32'h0002_0000, 32'h0002_0000));
    pending_items.push_back(mk(KIND_TEST, 7, 32'hfffe_0000, 32'h0001_0000, 32'h0001_0000,
                               32'hffff_0000, 32'h0002_0000, 32'h0002_0000));
    pending_items.push_back(mk(KIND_TEST, 3, 32'hffff_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                               32'h0001_0000));
    pending_items.push_back(mk(KIND_TEST, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h0001_0000,
                               32'h0001_0000));
    pending_items.push_back(mk(KIND_BAD, 0, '1, '1, '1, '1, '1, '1));
    pending_items.push_back(mk(KIND_ROW, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 0, 0));
    pending_items.push_back(mk(KIND_ROW, 3, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_ROW, 7, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_TEST, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000));
    pending_items.push_back(mk(KIND_ROW, 0, 32'h0001_0000, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(KIND_ROW, 1, 0, 32'h0001_0000, 0, 32'h0000_8000, 0, 0));
    pending_items.push_back(mk(KIND_ROW, 2, 0, 0, 32'h0001_0000, 32'hffff_8000, 0, 0));
    pending_items.push_back(mk(KIND_TEST, 0, 32'hfff0_0000, 32'hfff0_0000, 32'hfff0_0000,
                               32'h0010_0000, 32'h0010_0000, 32'h0010_0000));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_s[ph];
      recv_stall_pct = idle_r[ph];
      for (int n = 0; n < 275; n++) pending_items.push_back(rnd_item());
      if (ph == 1) begin
        while (pending_items.size() > 140) @(posedge clk);
        hold_send = 1'b1;
        while (expected_culls.size() != 0 || in_valid) @(posedge clk);
        hold_send = 1'b0;
      end
      wait_drained();
    end
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
